/* design/vsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package vsa_pkg;
  localparam int GRAIN_SHIFT_D  = 5;
  localparam int SIZE_CLASSES_D = 128;
  localparam int SLOT_POOL_D    = 4096;
  localparam int BUFFER_POOL_D  = 32;
  localparam int FORMATS_D      = 18;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [2:0] ST_REUSED  = 3'd0;
  localparam logic [2:0] ST_CARVED  = 3'd1;
  localparam logic [2:0] ST_NEWBUF  = 3'd2;
  localparam logic [2:0] ST_BADSIZE = 3'd3;
  localparam logic [2:0] ST_NOSLOT  = 3'd4;
  localparam logic [2:0] ST_NOBUF   = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the input item
    logic clear_start; // begin a clearing sweep
    logic clear_step;  // one free list entry cleared
    logic rd_free;     // read free list head
    logic rd_slot;     // read slot tables at head
    logic pop;         // pop free list, emit reused
    logic walk_first;  // take format head as walk pointer
    logic walk_step;   // examine buffer at walk pointer
    logic carve;       // carve from buffer at walk pointer
    logic newbuf;      // open buffer
    logic rel_rd;      // read slot tables for release
    logic rel_rd2;     // read free head for release
    logic rel_push;    // push released slot
    logic emit;        // load output register
    logic [2:0] st;    // status code to emit
    logic emit_slot;   // status carries slot fields
  } vsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic bad;         // bad size or format
    logic free_hit;    // free list head valid
    logic slots_full;
    logic walk_end;    // walk pointer empty or steps spent
    logic fits;        // buffer at walk pointer has room
    logic bufs_full;
    logic rel_ok;      // release is valid
    logic out_busy;    // output register occupied
  } vsa_stat_t;
endpackage
`default_nettype wire

/* design/vsa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/vsa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module vsa_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire [1:0]          in_op,
  output logic               in_ready,
  output vsa_pkg::vsa_cmd_t  cmd,
  input  vsa_pkg::vsa_stat_t stat
);
  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_CHECK = 12'b000000000100,
    S_FREE  = 12'b000000001000,
    S_SLOT  = 12'b000000010000,
    S_DEC   = 12'b000000100000,
    S_WALK  = 12'b000001000000,
    S_WTEST = 12'b000010000000,
    S_REL   = 12'b000100000000,
    S_REL2  = 12'b001000000000,
    S_REL3  = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] op, op_next;
  logic [2:0] st, st_next;
  logic es, es_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      op <= vsa_pkg::OP_GET;
      st <= vsa_pkg::ST_DONE;
      es <= 1'b0;
    end else begin
      state <= state_next;
      op <= op_next;
      st <= st_next;
      es <= es_next;
    end
  end

  // sequencing of one item
  always_comb begin
    state_next = state;
    op_next = op;
    st_next = st;
    es_next = es;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_next = in_op;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        es_next = 1'b0;
        if (op == vsa_pkg::OP_GET) begin
          if (stat.bad) begin
            st_next = vsa_pkg::ST_BADSIZE;
            state_next = S_EMIT;
          end else begin
            cmd.rd_free = 1'b1;
            state_next = S_FREE;
          end
        end else if (op == vsa_pkg::OP_RELEASE) begin
          state_next = S_REL;
        end else if (op == vsa_pkg::OP_CLEAR) begin
          cmd.clear_start = 1'b1;
          st_next = vsa_pkg::ST_DONE;
          state_next = S_EMIT;
        end else begin
          st_next = vsa_pkg::ST_DONE;
          state_next = S_EMIT;
        end
      end
      S_FREE: begin
        cmd.rd_slot = 1'b1;
        state_next = S_SLOT;
      end
      S_SLOT: begin
        cmd.rd_slot = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (stat.free_hit) begin
          cmd.pop = 1'b1;
          st_next = vsa_pkg::ST_REUSED;
          es_next = 1'b1;
          state_next = S_EMIT;
        end else if (stat.slots_full) begin
          st_next = vsa_pkg::ST_NOSLOT;
          state_next = S_EMIT;
        end else begin
          cmd.walk_first = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: state_next = S_WTEST;
      S_WTEST: begin
        if (stat.walk_end) begin
          if (stat.bufs_full) begin
            st_next = vsa_pkg::ST_NOBUF;
          end else begin
            cmd.newbuf = 1'b1;
            st_next = vsa_pkg::ST_NEWBUF;
            es_next = 1'b1;
          end
          state_next = S_EMIT;
        end else if (stat.fits) begin
          cmd.carve = 1'b1;
          st_next = vsa_pkg::ST_CARVED;
          es_next = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
          state_next = S_WALK;
        end
      end
      S_REL: begin
        cmd.rel_rd = 1'b1;
        state_next = S_REL2;
      end
      S_REL2: begin
        cmd.rel_rd2 = 1'b1;
        state_next = S_REL3;
      end
      S_REL3: begin
        if (stat.rel_ok) cmd.rel_push = 1'b1;
        st_next = vsa_pkg::ST_DONE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          state_next = (op == vsa_pkg::OP_CLEAR) ? S_CLR : S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
    cmd.st = st;
    cmd.emit_slot = es;
  end
endmodule
`default_nettype wire

/* design/vsa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module vsa_datapath #(
  parameter int GRAIN_SHIFT  = vsa_pkg::GRAIN_SHIFT_D,
  parameter int SIZE_CLASSES = vsa_pkg::SIZE_CLASSES_D,
  parameter int SLOT_POOL    = vsa_pkg::SLOT_POOL_D,
  parameter int BUFFER_POOL  = vsa_pkg::BUFFER_POOL_D,
  parameter int FORMATS      = vsa_pkg::FORMATS_D
) (
  input  wire                 clk,
  input  wire                 rst,
  input  vsa_pkg::vsa_cmd_t   cmd,
  output vsa_pkg::vsa_stat_t  stat,
  input  wire [4:0]           in_format,
  input  wire [15:0]          in_size,
  input  wire [11:0]          in_slot,
  input  wire [15:0]          dflt_size,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [2:0]          o_status,
  output logic [11:0]         o_slot,
  output logic [4:0]          o_buffer,
  output logic [15:0]         o_start,
  output logic [12:0]         o_length,
  output logic [15:0]         o_newsize
);
  localparam int FL_DEPTH = FORMATS * SIZE_CLASSES;
  localparam int FLW = $clog2(FL_DEPTH);
  localparam int CLW = $clog2(SIZE_CLASSES) + 1;
  localparam int BW  = $clog2(BUFFER_POOL) > 0 ? $clog2(BUFFER_POOL) : 1;
  localparam int BDEPTH = 1 << BW;
  localparam logic [12:0] NO_SLOT = 13'h1000;
  localparam logic [5:0]  NO_BUF  = 6'h20;
  localparam logic [15:0] GMASK = 16'((1 << GRAIN_SHIFT) - 1);

  // captured item
  logic [4:0] fmt;
  logic [15:0] req;
  logic [11:0] sid;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fmt <= in_format;
      req <= in_size;
      sid <= in_slot;
    end
  end

  // rounding and class
  logic [16:0] rounded17;
  logic [16:0] cls17;
  logic [12:0] rlen;
  assign rounded17 = ({1'b0, req} + {1'b0, GMASK}) & ~{1'b0, GMASK};
  assign cls17 = (rounded17 >> GRAIN_SHIFT) - 17'd1;
  assign rlen = rounded17[12:0];
  assign stat.bad = (rounded17 == 17'd0) || (32'(fmt) >= FORMATS) ||
                    (32'(cls17) >= SIZE_CLASSES);

  // free list heads, cleared by a sweep
  logic [FLW-1:0] clr_idx;
  logic clr_run;
  logic [FLW-1:0] fl_idx, rel_idx;
  logic [12:0] fl_rd;
  logic fl_we;
  logic [FLW-1:0] fl_wa, fl_ra;
  logic [12:0] fl_wd;
  assign fl_idx = FLW'(32'(fmt) * SIZE_CLASSES + 32'(cls17[CLW-1:0]));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      clr_idx <= '0;
      clr_run <= 1'b1;
    end else if (cmd.clear_step && clr_run) begin
      if (32'(clr_idx) == FL_DEPTH - 1) clr_run <= 1'b0;
      else clr_idx <= clr_idx + FLW'(1);
    end
  end
  assign stat.clear_done = !clr_run;

  // slot tables
  logic [12:0] sn_rd, sl_rd;
  logic [15:0] sb_rd;
  logic [4:0]  so_rd;
  logic sl_we;
  logic [11:0] s_wa, s_ra;
  logic [12:0] sn_wd;
  logic sn_we;
  logic [11:0] sn_wa;

  // buffer tables in flip-flops (small, read at the walk pointer and at the release owner)
  logic [4:0]  bfmt [BDEPTH];
  logic [15:0] bcap [BDEPTH];
  logic [15:0] bfill [BDEPTH];
  logic [5:0]  blink [BDEPTH];
  logic [5:0]  fhead [FORMATS];
  logic [12:0] slots_used;
  logic [5:0]  bufs_used;
  logic [5:0]  wptr;
  logic [5:0]  steps;
  logic [11:0] head;
  logic [12:0] head_raw;
  logic [4:0]  fidx;
  assign fidx = (32'(fmt) < FORMATS) ? fmt : 5'd0;

  // write selection for free heads
  always_comb begin
    fl_we = 1'b0;
    fl_wa = fl_idx;
    fl_wd = sn_rd;
    if (clr_run) begin
      fl_we = 1'b1;
      fl_wa = clr_idx;
      fl_wd = NO_SLOT;
    end else if (cmd.pop) begin
      fl_we = 1'b1;
    end else if (cmd.rel_push) begin
      fl_we = 1'b1;
      fl_wa = rel_idx;
      fl_wd = {1'b0, sid};
    end
    fl_ra = cmd.rel_rd2 ? rel_idx : fl_idx;
  end

  vsa_ram #(.WIDTH(13), .DEPTH(FL_DEPTH)) u_free (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));

  always_ff @(posedge clk) begin
    if (cmd.rd_slot) head_raw <= fl_rd;
  end
  assign head = head_raw[11:0];
  assign stat.free_hit = (32'(head_raw) < SLOT_POOL);
  assign stat.slots_full = (32'(slots_used) >= SLOT_POOL);

  // slot table read address: free head after it lands, else release id
  assign s_ra = cmd.rd_slot ? fl_rd[11:0] : sid;
  assign sl_we = cmd.carve || (cmd.newbuf && !stat.bufs_full);
  assign s_wa = slots_used[11:0];

  logic [15:0] carve_base;
  logic [4:0]  carve_buf;
  assign carve_base = cmd.carve ? bfill[wptr[BW-1:0]] : 16'd0;
  assign carve_buf  = cmd.carve ? 5'(wptr) : 5'(bufs_used);

  // a pushed slot links to the head read at its list index
  always_comb begin
    sn_we = sl_we || cmd.rel_push;
    sn_wa = cmd.rel_push ? sid : s_wa;
    sn_wd = cmd.rel_push ? fl_rd : NO_SLOT;
  end

  vsa_ram #(.WIDTH(13), .DEPTH(SLOT_POOL)) u_next (
    .clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(s_ra), .rdata(sn_rd));
  vsa_ram #(.WIDTH(13), .DEPTH(SLOT_POOL)) u_len (
    .clk(clk), .we(sl_we), .waddr(s_wa), .wdata(rlen), .raddr(s_ra), .rdata(sl_rd));
  vsa_ram #(.WIDTH(16), .DEPTH(SLOT_POOL)) u_base (
    .clk(clk), .we(sl_we), .waddr(s_wa), .wdata(carve_base), .raddr(s_ra), .rdata(sb_rd));
  vsa_ram #(.WIDTH(5), .DEPTH(SLOT_POOL)) u_owner (
    .clk(clk), .we(sl_we), .waddr(s_wa), .wdata(carve_buf), .raddr(s_ra), .rdata(so_rd));

  // release checks, slot data latched once the read at the id lands
  logic [12:0] rlen_q;
  logic [4:0]  rown_q;
  logic [4:0]  rfmt;
  logic [16:0] rcls;
  logic        rel_ok_q;
  assign rfmt = bfmt[rown_q[BW-1:0]];
  assign rcls = (17'(rlen_q) >> GRAIN_SHIFT) - 17'd1;
  assign rel_idx = FLW'(32'(rfmt) * SIZE_CLASSES + 32'(rcls[CLW-1:0]));
  always_ff @(posedge clk) begin
    if (cmd.rel_rd) begin
      rlen_q <= sl_rd;
      rown_q <= so_rd;
    end
  end
  always_comb begin
    rel_ok_q = ({1'b0, sid} < slots_used) && (32'(rown_q) < BUFFER_POOL) &&
               (32'(rfmt) < FORMATS) && (32'(rcls) < SIZE_CLASSES);
  end
  assign stat.rel_ok = rel_ok_q;

  // walk
  logic [15:0] cap_w, fill_w, room;
  assign cap_w = bcap[wptr[BW-1:0]];
  assign fill_w = bfill[wptr[BW-1:0]];
  assign room = cap_w - fill_w;
  assign stat.fits = (cap_w >= fill_w) && ({1'b0, room} >= rounded17);
  assign stat.walk_end = (32'(wptr) >= BUFFER_POOL) || (32'(steps) >= BUFFER_POOL);
  assign stat.bufs_full = (32'(bufs_used) >= BUFFER_POOL);

  logic [15:0] newcap;
  assign newcap = ({1'b0, dflt_size} > rounded17) ? dflt_size : rounded17[15:0];

  logic [15:0] rlen_q2;
  assign rlen_q2 = rounded17[15:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      slots_used <= '0;
      bufs_used <= '0;
      for (int i = 0; i < FORMATS; i++) fhead[i] <= NO_BUF;
    end else begin
      if (cmd.carve) begin
        bfill[wptr[BW-1:0]] <= fill_w + rlen_q2;
        slots_used <= slots_used + 13'd1;
      end
      if (cmd.newbuf && !stat.bufs_full) begin
        blink[bufs_used[BW-1:0]] <= fhead[fidx];
        fhead[fidx] <= bufs_used;
        bfmt[bufs_used[BW-1:0]] <= fmt;
        bcap[bufs_used[BW-1:0]] <= newcap;
        bfill[bufs_used[BW-1:0]] <= rounded17[15:0];
        bufs_used <= bufs_used + 6'd1;
        slots_used <= slots_used + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_first) begin
      wptr <= fhead[fidx];
      steps <= '0;
    end else if (cmd.walk_step) begin
      wptr <= blink[wptr[BW-1:0]];
      steps <= steps + 6'd1;
    end
  end

  // popped slot fields
  logic [12:0] pl;
  logic [15:0] pb;
  logic [4:0]  po;
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      pl <= sl_rd;
      pb <= sb_rd;
      po <= so_rd;
    end
  end
  logic sel_pop;
  logic [11:0] e_slot;
  logic [4:0]  e_buf;
  logic [15:0] e_start, e_new;
  logic [12:0] e_len;
  always_ff @(posedge clk) begin
    if (cmd.pop) sel_pop <= 1'b1;
    else if (cmd.carve || cmd.newbuf) sel_pop <= 1'b0;
    if (cmd.pop) e_slot <= head;
    if (cmd.carve) begin
      e_slot <= slots_used[11:0];
      e_buf <= 5'(wptr);
      e_start <= fill_w;
      e_len <= rlen;
      e_new <= 16'd0;
    end
    if (cmd.newbuf) begin
      e_slot <= slots_used[11:0];
      e_buf <= 5'(bufs_used);
      e_start <= 16'd0;
      e_len <= rlen;
      e_new <= newcap;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_status <= cmd.st;
      if (!cmd.emit_slot) begin
        o_slot <= '0; o_buffer <= '0; o_start <= '0; o_length <= '0; o_newsize <= '0;
      end else if (sel_pop) begin
        o_slot <= e_slot; o_buffer <= po; o_start <= pb; o_length <= pl; o_newsize <= '0;
      end else begin
        o_slot <= e_slot; o_buffer <= e_buf; o_start <= e_start; o_length <= e_len;
        o_newsize <= (cmd.st == vsa_pkg::ST_NEWBUF) ? e_new : 16'd0;
      end
    end
  end
  assign stat.out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire

/* design/vertex_slot_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Vertex slot allocator.
// Slave channel s_axis_*: one op per transaction (get, release, clear).
// Master channel m_axis_*: exactly one result per op, in order.
// cfg_*: write of default_buffer_size; write only while idle.
// One op at a time: the next op is accepted only after the result of the
// last one is loaded into the output register. A get that finds no
// released slot, with slots left, walks the format's buffers (up to
// BUFFER_POOL of them) before it carves, opens a new buffer or reports
// no buffers.
// Result sits in an output register; a stalled receiver holds the result
// and the next result waits in the controller until the register frees.
// After reset and after a clear op the free list heads are swept one
// entry a cycle (FORMATS*SIZE_CLASSES entries, 2304 by default) with the
// slave channel not ready; the cfg channel stays open.
// The configured buffer size survives a clear op.
module vertex_slot_allocator #(
  parameter int GRAIN_SHIFT  = vsa_pkg::GRAIN_SHIFT_D,
  parameter int SIZE_CLASSES = vsa_pkg::SIZE_CLASSES_D,
  parameter int SLOT_POOL    = vsa_pkg::SLOT_POOL_D,
  parameter int BUFFER_POOL  = vsa_pkg::BUFFER_POOL_D,
  parameter int FORMATS      = vsa_pkg::FORMATS_D
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], format[6:2], request_size[22:7], slot_id[34:23], zero fill
  input  wire [39:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[2:0], out_slot[14:3], out_buffer[19:15], slot_start[35:20],
  // slot_length[48:36], new_buffer_size[64:49], zero fill
  output logic [71:0] m_axis_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [15:0]  cfg_data
);
  vsa_pkg::vsa_cmd_t  cmd;
  vsa_pkg::vsa_stat_t stat;
  logic [15:0] dflt;
  logic [2:0] st;
  logic [11:0] sl;
  logic [4:0] bu;
  logic [15:0] ss, nb;
  logic [12:0] ln;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) dflt <= 16'd8192;
    else if (cfg_valid) dflt <= cfg_data;
  end

  vsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_op(s_axis_tdata[1:0]),
    .in_ready(s_axis_tready), .cmd(cmd), .stat(stat));

  vsa_datapath #(
    .GRAIN_SHIFT(GRAIN_SHIFT), .SIZE_CLASSES(SIZE_CLASSES), .SLOT_POOL(SLOT_POOL),
    .BUFFER_POOL(BUFFER_POOL), .FORMATS(FORMATS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_format(s_axis_tdata[6:2]), .in_size(s_axis_tdata[22:7]),
    .in_slot(s_axis_tdata[34:23]), .dflt_size(dflt),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .o_status(st), .o_slot(sl), .o_buffer(bu), .o_start(ss), .o_length(ln),
    .o_newsize(nb));

  assign m_axis_tdata = {7'd0, nb, ln, ss, bu, sl, st};
endmodule
`default_nettype wire

/* sim/tb_vertex_slot_allocator.sv */
`timescale 1ns / 1ps
module tb_vertex_slot_allocator;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int GRAIN = 1 << vsa_pkg::GRAIN_SHIFT_D;
  localparam int NO_SLOT = vsa_pkg::SLOT_POOL_D;
  localparam int NO_BUF = vsa_pkg::BUFFER_POOL_D;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [2:0]  status;
    logic [11:0] slot;
    logic [4:0]  buf_id;
    logic [15:0] start;
    logic [12:0] length;
    logic [15:0] new_size;
  } alloc_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // op[1:0], format[6:2], request_size[22:7], slot_id[34:23], zero fill
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // status[2:0], out_slot[14:3], out_buffer[19:15], slot_start[35:20],
  // slot_length[48:36], new_buffer_size[64:49], zero fill
  logic [71:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  vertex_slot_allocator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // allocator shadow state
  int dflt_size;
  int free_head [vsa_pkg::FORMATS_D*vsa_pkg::SIZE_CLASSES_D];
  int slot_next [vsa_pkg::SLOT_POOL_D];
  int slot_len [vsa_pkg::SLOT_POOL_D];
  int slot_base [vsa_pkg::SLOT_POOL_D];
  int slot_owner [vsa_pkg::SLOT_POOL_D];
  int buf_fmt [vsa_pkg::BUFFER_POOL_D];
  int buf_cap [vsa_pkg::BUFFER_POOL_D];
  int buf_fill [vsa_pkg::BUFFER_POOL_D];
  int buf_link [vsa_pkg::BUFFER_POOL_D];
  int fmt_head [vsa_pkg::FORMATS_D];
  int slots_used, bufs_used;

  logic [39:0]   pending_ops[$];
  alloc_result_t expected_results[$];

  int  errors, idle_cycles;
  int  n_ops, n_reused, n_carved, n_newbuf, n_bad, n_noslot, n_nobuf, n_done;
  bit  tight;
  bit  stall_armed, stall_done;
  int  stall_cnt, rx_wait, tx_gap;
  bit  s_took, m_took, cfg_took;

  function automatic void wipe_allocator();
    foreach (free_head[i]) free_head[i] = NO_SLOT;
    foreach (fmt_head[i]) fmt_head[i] = NO_BUF;
    slots_used = 0;
    bufs_used = 0;
  endfunction

  function automatic alloc_result_t slot_fields(logic [2:0] st, int s);
    alloc_result_t r;
    r.status = st;
    r.slot = s[11:0];
    r.buf_id = slot_owner[s][4:0];
    r.start = slot_base[s][15:0];
    r.length = slot_len[s][12:0];
    r.new_size = '0;
    return r;
  endfunction

  function automatic int carve_slot(int b, int start, int len);
    int s;
    s = slots_used;
    slot_len[s] = len;
    slot_base[s] = start;
    slot_owner[s] = b;
    slot_next[s] = NO_SLOT;
    slots_used++;
    return s;
  endfunction

  // work out the answer to one op and advance the shadow state
  function automatic alloc_result_t allocate_op(logic [1:0] op, int fmt, int req, int sid);
    alloc_result_t r;
    int rounded, cls, idx, s, b, steps, owner;
    r = '{default: '0};
    r.status = vsa_pkg::ST_DONE;
    if (op == vsa_pkg::OP_RELEASE) begin
      if (sid < slots_used) begin
        owner = slot_owner[sid];
        idx = buf_fmt[owner] * vsa_pkg::SIZE_CLASSES_D
              + (slot_len[sid] >> vsa_pkg::GRAIN_SHIFT_D) - 1;
        slot_next[sid] = free_head[idx];
        free_head[idx] = sid;
      end
      return r;
    end
    if (op == vsa_pkg::OP_CLEAR) begin
      wipe_allocator();
      return r;
    end
    if (op != vsa_pkg::OP_GET) return r;
    r.status = vsa_pkg::ST_BADSIZE;
    rounded = (req + GRAIN - 1) & ~(GRAIN - 1);
    if (rounded == 0 || fmt >= vsa_pkg::FORMATS_D) return r;
    cls = (rounded >> vsa_pkg::GRAIN_SHIFT_D) - 1;
    if (cls >= vsa_pkg::SIZE_CLASSES_D) return r;
    idx = fmt * vsa_pkg::SIZE_CLASSES_D + cls;
    // reuse the newest released slot of this class
    s = free_head[idx];
    if (s < vsa_pkg::SLOT_POOL_D) begin
      free_head[idx] = slot_next[s];
      return slot_fields(vsa_pkg::ST_REUSED, s);
    end
    if (slots_used >= vsa_pkg::SLOT_POOL_D) begin
      r.status = vsa_pkg::ST_NOSLOT;
      return r;
    end
    // walk the format's buffers, newest first
    b = fmt_head[fmt];
    for (steps = 0; steps < vsa_pkg::BUFFER_POOL_D && b < vsa_pkg::BUFFER_POOL_D; steps++) begin
      if (buf_cap[b] >= buf_fill[b] && buf_cap[b] - buf_fill[b] >= rounded) begin
        s = carve_slot(b, buf_fill[b], rounded);
        buf_fill[b] += rounded;
        return slot_fields(vsa_pkg::ST_CARVED, s);
      end
      b = buf_link[b];
    end
    if (bufs_used >= vsa_pkg::BUFFER_POOL_D) begin
      r.status = vsa_pkg::ST_NOBUF;
      return r;
    end
    // open a fresh buffer
    b = bufs_used++;
    buf_link[b] = fmt_head[fmt];
    fmt_head[fmt] = b;
    buf_fmt[b] = fmt;
    buf_cap[b] = (dflt_size > rounded) ? dflt_size : rounded;
    buf_fill[b] = rounded;
    s = carve_slot(b, 0, rounded);
    r = slot_fields(vsa_pkg::ST_NEWBUF, s);
    r.new_size = buf_cap[b][15:0];
    return r;
  endfunction

  task automatic queue_op(logic [1:0] op, int fmt, int req, int sid);
    pending_ops.push_back({5'd0, sid[11:0], req[15:0], fmt[4:0], op});
    expected_results.push_back(allocate_op(op, fmt, req, sid));
    n_ops++;
  endtask

  // mostly well-formed traffic on a few formats, with some noise
  task automatic queue_random_ops(int count);
    int pick, fmt, req, sid;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      fmt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0:       req = $urandom_range(0, 65535);
        1:       req = 0;
        2:       req = $urandom_range(3000, 4096);
        default: req = $urandom_range(1, 256);
      endcase
      if (slots_used > 0 && $urandom_range(0, 7) != 0)
        sid = $urandom_range(0, slots_used - 1);
      else
        sid = $urandom_range(0, 4095);
      if (pick < 60)      queue_op(vsa_pkg::OP_GET, fmt, req, sid);
      else if (pick < 97) queue_op(vsa_pkg::OP_RELEASE, fmt, req, sid);
      else if (pick < 98) queue_op(vsa_pkg::OP_CLEAR, fmt, req, sid);
      else                queue_op(OP_SPARE, fmt, req, sid);
    end
  endtask

  // let everything drain, then give the block a quiet spell
  task automatic drain();
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_buffer_size(int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value[15:0];
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
    dflt_size = value;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stimulus
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tight = 1'b0;
    stall_armed = 1'b0;
    dflt_size = 8192;
    wipe_allocator();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_buffer_size(8192);
    // directed corners
    queue_op(vsa_pkg::OP_GET, 0, 0, 0);
    queue_op(vsa_pkg::OP_GET, 0, 4096, 0);
    queue_op(vsa_pkg::OP_GET, 0, 4097, 0);
    queue_op(vsa_pkg::OP_GET, 0, 65535, 0);
    queue_op(vsa_pkg::OP_GET, 17, 1, 0);
    queue_op(vsa_pkg::OP_GET, 18, 32, 0);
    queue_op(vsa_pkg::OP_GET, 31, 32, 0);
    queue_op(vsa_pkg::OP_GET, 0, 33, 0);
    queue_op(vsa_pkg::OP_RELEASE, 0, 0, 4095);
    queue_op(OP_SPARE, 31, 65535, 4095);
    queue_op(vsa_pkg::OP_RELEASE, 0, 0, 1);
    queue_op(vsa_pkg::OP_GET, 17, 32, 0);
    queue_op(vsa_pkg::OP_RELEASE, 0, 0, 2);
    queue_op(vsa_pkg::OP_RELEASE, 0, 0, 2);
    queue_op(vsa_pkg::OP_GET, 0, 64, 0);
    queue_op(vsa_pkg::OP_GET, 0, 50, 0);
    queue_op(vsa_pkg::OP_GET, 0, 64, 0);
    queue_op(vsa_pkg::OP_CLEAR, 0, 0, 0);
    queue_op(vsa_pkg::OP_GET, 5, 100, 0);
    queue_random_ops(450);
    drain();

    // tiny buffers run the buffer pool dry; the receiver holds off once
    write_buffer_size(32);
    stall_armed = 1'b1;
    queue_op(vsa_pkg::OP_CLEAR, 0, 0, 0);
    queue_random_ops(350);
    drain();

    // huge buffers, back to back
    write_buffer_size(65535);
    tight = 1'b1;
    queue_op(vsa_pkg::OP_CLEAR, 0, 0, 0);
    queue_random_ops(400);
    drain();
    tight = 1'b0;

    write_buffer_size(1);
    queue_op(vsa_pkg::OP_CLEAR, 0, 0, 0);
    queue_random_ops(400);
    drain();

    write_buffer_size($urandom_range(1, 65535));
    queue_random_ops(300);
    drain();

    $display("ops %0d: reused %0d carved %0d new buffer %0d bad size %0d",
             n_ops, n_reused, n_carved, n_newbuf, n_bad);
    $display("no slots %0d, no buffers %0d, release/clear/other %0d, five buffer sizes",
             n_noslot, n_nobuf, n_done);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // op driver
  always @(negedge clk) begin
    logic [39:0] op_word;
    bit          next_valid;
    if (!rst && (s_took || !s_axis_tvalid)) begin
      next_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_ops.size() > 0) begin
        op_word = pending_ops.pop_front();
        s_axis_tdata <= op_word;
        next_valid = 1'b1;
        tx_gap = tight ? 0 : $urandom_range(0, 13);
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // result receiver, with one long hold-off when armed
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_armed && !stall_done) begin
        stall_done = 1'b1;
        stall_cnt = 3000;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        if (m_took) rx_wait = tight ? 0 : $urandom_range(0, 13);
        if (rx_wait > 0) begin
          rx_wait--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    alloc_result_t want;
    s_took <= s_axis_tvalid && s_axis_tready;
    m_took <= m_axis_tvalid && m_axis_tready;
    cfg_took <= cfg_valid && cfg_ready;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        case (want.status)
          vsa_pkg::ST_REUSED:  n_reused++;
          vsa_pkg::ST_CARVED:  n_carved++;
          vsa_pkg::ST_NEWBUF:  n_newbuf++;
          vsa_pkg::ST_BADSIZE: n_bad++;
          vsa_pkg::ST_NOSLOT:  n_noslot++;
          vsa_pkg::ST_NOBUF:   n_nobuf++;
          default:             n_done++;
        endcase
        if (m_axis_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[14:3] !== want.slot) begin
          $error("out_slot: expected %0d, got %0d", want.slot, m_axis_tdata[14:3]);
          errors++;
        end
        if (m_axis_tdata[19:15] !== want.buf_id) begin
          $error("out_buffer: expected %0d, got %0d", want.buf_id, m_axis_tdata[19:15]);
          errors++;
        end
        if (m_axis_tdata[35:20] !== want.start) begin
          $error("slot_start: expected %0d, got %0d", want.start, m_axis_tdata[35:20]);
          errors++;
        end
        if (m_axis_tdata[48:36] !== want.length) begin
          $error("slot_length: expected %0d, got %0d", want.length, m_axis_tdata[48:36]);
          errors++;
        end
        if (m_axis_tdata[64:49] !== want.new_size) begin
          $error("new_buffer_size: expected %0d, got %0d", want.new_size,
                 m_axis_tdata[64:49]);
          errors++;
        end
      end
    end
  end

endmodule
